/* sv/chd_pkg.sv */
// Shared types, constants and helpers for the chunked transfer decoder.
package chd_pkg;

   localparam int SIZE_BITS = 32;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_SP = 8'h20;

   localparam logic [1:0] PH_SIZE0   = 2'd0;
   localparam logic [1:0] PH_SIZE1   = 2'd1;
   localparam logic [1:0] PH_DATA    = 2'd2;
   localparam logic [1:0] PH_TRAILER = 2'd3;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_AFTER_SP   = 3'd1;
   localparam logic [2:0] ERR_NO_LF      = 3'd2;
   localparam logic [2:0] ERR_NO_CR      = 3'd3;
   localparam logic [2:0] ERR_EMPTY_SIZE = 3'd4;
   localparam logic [2:0] ERR_BAD_HEX    = 3'd5;
   localparam logic [2:0] ERR_STRAY_LF   = 3'd6;
   localparam logic [2:0] ERR_OVERFLOW   = 3'd7;

   localparam int RSP_DATA_BITS = 16;

   typedef struct packed {
      logic [1:0]           phase;
      logic [SIZE_BITS-1:0] chunk_remaining;
      logic [1:0]           cr_count;
      logic [1:0]           lf_count;
      logic                 space_seen;
      logic                 done_flag;
      logic [2:0]           error_latch;
   } chd_state_type;

   // Bit 4 set means not a hex digit; else bits 3:0 hold the digit value.
   function automatic logic [4:0] hex_value(input logic [7:0] ch);
      logic [7:0] lc;
      lc = ch | 8'h20;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         hex_value = {1'b0, ch[3:0]};
      end else if (lc >= 8'h61 && lc <= 8'h66) begin
         hex_value = {1'b0, lc[3:0] + 4'd9};
      end else begin
         hex_value = 5'h10;
      end
   endfunction

endpackage

/* sv/chd_step.sv */
// Next-state and result logic for one body byte of the chunked decoder.
module chd_step
   import chd_pkg::*;
(
   input  logic          decode_enable,
   input  logic [7:0]    ch,
   input  chd_state_type cur,
   output chd_state_type nxt,
   output logic          payload_valid
);

   logic [4:0] hex;
   logic [1:0] lf_inc;

   assign hex    = hex_value(ch);
   assign lf_inc = cur.lf_count + 2'd1;

   always_comb begin
      nxt           = cur;
      payload_valid = 1'b0;
      if (!decode_enable) begin
         payload_valid = 1'b1;
      end else if (cur.done_flag || cur.error_latch != ERR_NONE) begin
         payload_valid = 1'b0;
      end else if (cur.space_seen) begin
         if (ch == CH_SP) begin
            nxt.space_seen = 1'b1;
         end else if (ch == CH_CR) begin
            nxt.space_seen = 1'b0;
            nxt.cr_count   = 2'd1;
         end else begin
            nxt.error_latch = ERR_AFTER_SP;
         end
      end else if (cur.cr_count > cur.lf_count) begin
         // line end: expecting LF
         if (ch != CH_LF) begin
            nxt.error_latch = ERR_NO_LF;
         end else begin
            nxt.lf_count = lf_inc;
            case (cur.phase)
               PH_SIZE1: begin
                  if (cur.chunk_remaining != '0) begin
                     nxt.phase    = PH_DATA;
                     nxt.cr_count = 2'd0;
                     nxt.lf_count = 2'd0;
                  end else begin
                     nxt.phase = PH_TRAILER;
                  end
               end
               PH_DATA: begin
                  nxt.phase    = PH_SIZE0;
                  nxt.cr_count = 2'd0;
                  nxt.lf_count = 2'd0;
               end
               PH_TRAILER: begin
                  if (cur.cr_count == 2'd2 && lf_inc == 2'd2) begin
                     nxt.done_flag = 1'b1;
                  end
               end
               default: begin
                  nxt.lf_count = lf_inc;
               end
            endcase
         end
      end else begin
         case (cur.phase)
            PH_DATA: begin
               if (cur.chunk_remaining == '0) begin
                  if (ch == CH_SP) begin
                     nxt.space_seen = 1'b1;
                  end else if (ch == CH_CR) begin
                     nxt.cr_count = 2'd1;
                  end else begin
                     nxt.error_latch = ERR_NO_CR;
                  end
               end else begin
                  nxt.chunk_remaining = cur.chunk_remaining - 1'b1;
                  payload_valid       = 1'b1;
               end
            end
            PH_SIZE0, PH_SIZE1: begin
               if (cur.phase == PH_SIZE0 && (ch == CH_CR || ch == CH_LF)) begin
                  nxt.error_latch = ERR_EMPTY_SIZE;
               end else begin
                  nxt.phase = PH_SIZE1;
                  if (ch == CH_SP) begin
                     nxt.space_seen = 1'b1;
                  end else if (ch == CH_CR) begin
                     nxt.cr_count = 2'd1;
                  end else if (hex[4]) begin
                     nxt.error_latch = ERR_BAD_HEX;
                  end else if (cur.chunk_remaining[SIZE_BITS-1 -: 4] != 4'd0) begin
                     nxt.error_latch = ERR_OVERFLOW;
                  end else begin
                     nxt.chunk_remaining = {cur.chunk_remaining[SIZE_BITS-5:0], hex[3:0]};
                  end
               end
            end
            default: begin
               // trailer lines
               if (ch == CH_CR) begin
                  nxt.cr_count = cur.cr_count + 2'd1;
               end else if (ch != CH_LF) begin
                  nxt.cr_count = 2'd0;
                  nxt.lf_count = 2'd0;
               end else begin
                  nxt.error_latch = ERR_STRAY_LF;
               end
            end
         endcase
      end
   end

endmodule

/* sv/http_chunked_decoder.sv */
// Top level of the HTTP/1.1 chunked transfer decoder.
//
// Usage:
//   req_ channel: one raw body byte per item in req_tdata[7:0].
//   rsp_ channel: exactly one result item per input item, in order.
//     rsp_tdata = {3'b0, error_code, finished, payload_valid, payload_byte}.
//     payload_byte is zero when payload_valid is low; downstream keeps
//     items with payload_valid set and watches finished / error_code.
//   csr_ port: csr_wen writes csr_wdata[0] into decode_enable (reset 0,
//     i.e. pass-through). Write only while the block holds no item.
// Timing:
//   An item is captured in the input register and decoded from there into
//   the result register, which offers its result once it is free. One item
//   per cycle sustained while rsp_tready stays high; the decode state
//   feeds back from the state register through the step logic.
// Reset: clears decoder state, both pipeline stages and decode_enable.
// Stall: with rsp_tready low the result register holds, the input register
//   still takes one more item, then req_tready drops until space frees.
module http_chunked_decoder
   import chd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,  // [7:0] in_byte
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [7:0] payload_byte, [8] payload_valid, [9] finished, [12:10] error_code
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                     csr_wen,
   input  logic [0:0]               csr_wdata
);

   logic                     decode_enable_ff;
   logic                     in_valid_ff, in_valid_in;
   logic [7:0]               in_byte_ff;
   logic                     out_valid_ff, out_valid_in;
   logic [RSP_DATA_BITS-1:0] out_data_ff, out_data_in;
   chd_state_type            state_ff, state_in, state_nxt;
   logic                     step_valid;
   logic                     out_free, move;

   chd_step u_step (
      .decode_enable (decode_enable_ff),
      .ch            (in_byte_ff),
      .cur           (state_ff),
      .nxt           (state_nxt),
      .payload_valid (step_valid)
   );

   // handshake: output register frees when empty or being taken
   assign out_free   = !out_valid_ff || rsp_tready;
   assign move       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || move;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !move);
   assign out_valid_in = move || (out_valid_ff && !rsp_tready);
   assign state_in     = move ? state_nxt : state_ff;

   always_comb begin
      out_data_in = out_data_ff;
      if (move) begin
         out_data_in = {3'b000, state_nxt.error_latch, state_nxt.done_flag, step_valid,
                        step_valid ? in_byte_ff : 8'h00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decode_enable_ff         <= 1'b0;
         in_valid_ff              <= 1'b0;
         out_valid_ff             <= 1'b0;
         state_ff.phase           <= PH_SIZE0;
         state_ff.chunk_remaining <= '0;
         state_ff.cr_count        <= 2'd0;
         state_ff.lf_count        <= 2'd0;
         state_ff.space_seen      <= 1'b0;
         state_ff.done_flag       <= 1'b0;
         state_ff.error_latch     <= ERR_NONE;
      end else begin
         if (csr_wen) begin
            decode_enable_ff <= csr_wdata[0];
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

/* verif/http_chunked_decoder_test.sv */
// Self-checking testbench for the chunked decoder: directed and random bodies checked by a predictor.
`timescale 1ns / 1ps

module http_chunked_decoder_test;
   import chd_pkg::*;

   // One result item as the predictor sees it.
   typedef struct packed {
      logic [7:0] payload;
      logic       pay_valid;
      logic       fin;
      logic [2:0] err;
   } dec_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [7:0]               req_tdata = 8'h00;  // [7:0] in_byte
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // [7:0] payload_byte, [8] payload_valid, [9] finished, [12:10] error_code
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_wen = 1'b0;
   logic [0:0]               csr_wdata = 1'b0;

   http_chunked_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // ------------------------------------------------------------------
   // Decoder predictor: private copy of the deframing state.
   // ------------------------------------------------------------------
   logic                 decode_on  = 1'b0;   // mirrors decode_enable
   logic [1:0]           dec_phase  = PH_SIZE0;
   logic [SIZE_BITS-1:0] bytes_left = '0;     // size being parsed, or data left
   logic [1:0]           line_crs   = 2'd0;
   logic [1:0]           line_lfs   = 2'd0;
   logic                 in_spaces  = 1'b0;   // skipping trailing blanks
   logic                 saw_end    = 1'b0;
   logic [2:0]           sticky_err = ERR_NONE;

   // Advances the framing state by one byte; returns 1 for a payload byte.
   function automatic logic dechunk_core(input logic [7:0] ch);
      logic [7:0] lc;
      logic [4:0] digit;
      lc = ch | 8'h20;
      if (in_spaces) begin
         if (ch == CH_SP) return 1'b0;
         if (ch == CH_CR) begin
            in_spaces = 1'b0;
            line_crs  = 2'd1;
            return 1'b0;
         end
         sticky_err = ERR_AFTER_SP;
         return 1'b0;
      end
      // CR pending: only LF may follow.
      if (line_crs > line_lfs) begin
         if (ch != CH_LF) begin
            sticky_err = ERR_NO_LF;
            return 1'b0;
         end
         line_lfs = line_lfs + 2'd1;
         case (dec_phase)
            PH_SIZE1: begin
               if (bytes_left != '0) begin
                  dec_phase = PH_DATA;
                  line_crs  = 2'd0;
                  line_lfs  = 2'd0;
               end else begin
                  dec_phase = PH_TRAILER;  // counts carry on into the trailer
               end
            end
            PH_DATA: begin
               dec_phase = PH_SIZE0;
               line_crs  = 2'd0;
               line_lfs  = 2'd0;
            end
            PH_TRAILER: begin
               if (line_crs == 2'd2 && line_lfs == 2'd2) saw_end = 1'b1;
            end
            default: ;
         endcase
         return 1'b0;
      end
      case (dec_phase)
         PH_DATA: begin
            if (bytes_left == '0) begin
               if (ch == CH_SP) in_spaces = 1'b1;
               else if (ch == CH_CR) line_crs = 2'd1;
               else sticky_err = ERR_NO_CR;
               return 1'b0;
            end
            bytes_left = bytes_left - 1'b1;
            return 1'b1;
         end
         PH_SIZE0, PH_SIZE1: begin
            if (dec_phase == PH_SIZE0) begin
               if (ch == CH_CR || ch == CH_LF) begin
                  sticky_err = ERR_EMPTY_SIZE;
                  return 1'b0;
               end
               dec_phase = PH_SIZE1;
            end
            if (ch == CH_SP) begin
               in_spaces = 1'b1;
               return 1'b0;
            end
            if (ch == CH_CR) begin
               line_crs = 2'd1;
               return 1'b0;
            end
            if (ch >= "0" && ch <= "9") digit = {1'b0, ch[3:0]};
            else if (lc >= "a" && lc <= "f") digit = 5'(lc - "a" + 8'd10);
            else digit = 5'h10;
            if (digit[4]) begin
               sticky_err = ERR_BAD_HEX;
               return 1'b0;
            end
            // top nibble busy: one more digit would not fit
            if (bytes_left[SIZE_BITS-1 -: 4] != 4'h0) begin
               sticky_err = ERR_OVERFLOW;
               return 1'b0;
            end
            bytes_left = {bytes_left[SIZE_BITS-5:0], digit[3:0]};
            return 1'b0;
         end
         default: begin
            // trailer: CRs count up, any header byte restarts the line
            if (ch == CH_CR) line_crs = line_crs + 2'd1;
            else if (ch != CH_LF) begin
               line_crs = 2'd0;
               line_lfs = 2'd0;
            end else sticky_err = ERR_STRAY_LF;
            return 1'b0;
         end
      endcase
   endfunction

   // Expected result item for one accepted input byte.
   function automatic dec_result_type dechunk_step(input logic [7:0] ch);
      dec_result_type r;
      logic           v;
      if (!decode_on) v = 1'b1;                            // pass-through
      else if (saw_end || sticky_err != ERR_NONE) v = 1'b0; // dropped, state frozen
      else v = dechunk_core(ch);
      r.payload   = v ? ch : 8'h00;
      r.pay_valid = v;
      r.fin       = saw_end;
      r.err       = sticky_err;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Shared queues and knobs.
   // ------------------------------------------------------------------
   logic [7:0]     body_bytes[$];    // items waiting for the driver
   logic [7:0]     frame_bytes[$];   // staged body text, not yet released
   dec_result_type decoded_q[$];     // predicted result items, oldest first
   int             items_queued = 0;
   int             fail_count   = 0;
   bit             steady       = 1'b0;  // both sides run with no idle cycles
   int             hold_asked   = 0;     // long receiver hold-offs requested
   int             hold_served  = 0;
   int             hold_left    = 0;
   dec_result_type want;

   // ------------------------------------------------------------------
   // Driver: offers one byte per item, predicts it on acceptance.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) decoded_q.push_back(dechunk_step(req_tdata));
         // load a new item when the slot is free or just went through
         if (!req_tvalid || req_tready) begin
            if (body_bytes.size() != 0 && (steady || $urandom_range(0, 99) >= 20)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= body_bytes.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: checks result items and drives the back-pressure.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_q.size() == 0) begin
               $display("%0t: result item with none expected: %h", $time, rsp_tdata);
               fail_count++;
            end else begin
               want = decoded_q.pop_front();
               if (rsp_tdata[7:0] !== want.payload) begin
                  $display("%0t: payload_byte expected %02h got %02h",
                           $time, want.payload, rsp_tdata[7:0]);
                  fail_count++;
               end
               if (rsp_tdata[8] !== want.pay_valid) begin
                  $display("%0t: payload_valid expected %0d got %0d",
                           $time, want.pay_valid, rsp_tdata[8]);
                  fail_count++;
               end
               if (rsp_tdata[9] !== want.fin) begin
                  $display("%0t: finished expected %0d got %0d",
                           $time, want.fin, rsp_tdata[9]);
                  fail_count++;
               end
               if (rsp_tdata[12:10] !== want.err) begin
                  $display("%0t: error_code expected %0d got %0d",
                           $time, want.err, rsp_tdata[12:10]);
                  fail_count++;
               end
            end
         end
         // long hold-off: lets the pipe fill so req_tready must drop
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_served != hold_asked) begin
            hold_served++;
            hold_left = 60;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || $urandom_range(0, 99) >= 20;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------
   task automatic stage(input logic [7:0] b);
      frame_bytes.push_back(b);
   endtask

   task automatic feed(input int n);
      repeat (n) begin
         if (frame_bytes.size() != 0) begin
            body_bytes.push_back(frame_bytes.pop_front());
            items_queued++;
         end
      end
   endtask

   task automatic flush();
      feed(frame_bytes.size());
   endtask

   task automatic stage_noise(input int n);
      repeat (n) stage(8'($urandom_range(0, 255)));
   endtask

   // Sender pause: everything offered has come back, plus pipe latency.
   task automatic wait_drained();
      do @(posedge clock);
      while (body_bytes.size() != 0 || req_tvalid || decoded_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Only called with the block idle.
   task automatic write_enable(input logic v);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen   <= 1'b0;
      decode_on = v;
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
      if (nib < 4'd10) return 8'h30 + nib;
      return (upper ? 8'h41 : 8'h61) + nib - 8'd10;
   endfunction

   // Size line: optional leading zeros, mixed-case hex, optional blanks, CR LF.
   task automatic emit_size(input int unsigned size);
      int ndig;
      int i;
      ndig = 1;
      while (ndig < 8 && (size >> (4 * ndig)) != 0) ndig++;
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 9)) stage("0");
      for (i = ndig - 1; i >= 0; i--) stage(hex_char(4'(size >> (4 * i)), $urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) stage(CH_SP);
      stage(CH_CR);
      stage(CH_LF);
   endtask

   task automatic emit_chunk(input int unsigned size);
      emit_size(size);
      stage_noise(size);
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) stage(CH_SP);
      stage(CH_CR);
      stage(CH_LF);
   endtask

   // ------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------
   initial begin
      int         batch;
      int         cut;
      logic [2:0] end_code;
      logic [7:0] edge_bytes[7];

      edge_bytes = '{8'h00, 8'hFF, CH_CR, CH_LF, CH_SP, 8'h55, 8'hAA};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // pass-through straight out of reset (decode_enable resets to 0)
      foreach (edge_bytes[i]) stage(edge_bytes[i]);
      flush();
      wait_drained();

      // directed chunks: leading zero, blank before CR, blank after data,
      // data holding the extremes and a CR
      write_enable(1'b1);
      stage("0"); stage("2"); stage(CH_SP); stage(CH_CR); stage(CH_LF);
      stage(8'h00); stage(8'hFF); stage(CH_SP); stage(CH_CR); stage(CH_LF);
      stage("1"); stage(CH_CR); stage(CH_LF); stage(CH_CR); stage(CH_CR); stage(CH_LF);
      flush();
      wait_drained();

      // random pass-through
      write_enable(1'b0);
      stage_noise(120);
      flush();
      wait_drained();
      write_enable(1'b1);

      // bulk: well-formed chunks, cut at a random byte; sometimes the
      // decoder is switched off there and must resume where it stopped
      batch = 0;
      while (items_queued < 640) begin
         steady = (batch == 2);
         repeat ($urandom_range(3, 8))
            emit_chunk(($urandom_range(0, 9) == 0) ? $urandom_range(17, 80)
                                                    : $urandom_range(1, 16));
         if (batch % 10 == 0) hold_asked++;
         cut = $urandom_range(1, frame_bytes.size() - 1);
         feed(cut);
         if ($urandom_range(0, 2) == 0) begin
            wait_drained();
            write_enable(1'b0);
            body_bytes.push_back(8'($urandom_range(0, 255)));
            repeat ($urandom_range(3, 15)) body_bytes.push_back(8'($urandom_range(0, 255)));
            wait_drained();
            write_enable(1'b1);
         end
         flush();
         batch++;
      end
      steady = 1'b0;
      wait_drained();

      // ending: the terminator or one malformed case, picked at random;
      // either one freezes the decoder for the rest of the run
      end_code = 3'($urandom_range(0, 7));
      case (end_code)
         ERR_NONE: begin
            stage("0");
            stage(CH_CR);
            stage(CH_LF);
            repeat ($urandom_range(0, 2)) begin
               repeat ($urandom_range(1, 8)) stage(8'($urandom_range(32, 126)));
               stage(CH_CR);
               stage(CH_LF);
            end
            stage(CH_CR);
            stage(CH_LF);
         end
         ERR_AFTER_SP: begin stage("5"); stage(CH_SP); stage("x"); end
         ERR_NO_LF:    begin stage("5"); stage(CH_CR); stage("x"); end
         ERR_NO_CR: begin
            emit_size(3);
            stage_noise(3);
            stage("x");
         end
         ERR_EMPTY_SIZE: stage(CH_CR);
         ERR_BAD_HEX:    begin stage("5"); stage(";"); end
         ERR_STRAY_LF:   begin stage("0"); stage(CH_CR); stage(CH_LF); stage(CH_LF); end
         default: begin
            // FFFFFFFF fits, one more digit does not
            repeat (8) stage(hex_char(4'hF, $urandom_range(0, 1)));
            stage("1");
         end
      endcase
      stage_noise(20);          // dropped, flags held
      flush();
      wait_drained();
      write_enable(1'b0);       // pass-through still shows the held flags
      stage_noise(20);
      flush();
      wait_drained();
      write_enable(1'b1);
      stage_noise(6);
      flush();
      wait_drained();

      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

/* sim.f */
sv/chd_pkg.sv
sv/chd_step.sv
sv/http_chunked_decoder.sv
verif/http_chunked_decoder_test.sv
